[rtl/sync_framed_packet_checker_crc16_unit_defines.svh]
// Assertion helpers shared by the checker RTL.
// Each helper expects signals named clk and rst_n in the using module.
`ifndef SYNC_FRAMED_PACKET_CHECKER_CRC16_UNIT_DEFINES_SVH
`define SYNC_FRAMED_PACKET_CHECKER_CRC16_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SFPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sfpc_pkg.sv]
package sfpc_pkg;

  localparam logic [7:0]  SYNC_FIRST     = 8'h55;
  localparam logic [7:0]  SYNC_SECOND    = 8'hAA;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [8:0]  HDR_AFTER_LEN  = 9'd5;
  localparam logic [7:0]  LEN_MIN        = 8'd4;
  localparam logic [7:0]  LENGTH_LIMIT   = 8'd30;
  localparam logic [7:0]  COUNT_MAX      = 8'd255;

  // Packet offsets of the header and captured fields
  localparam logic [7:0] OFS_SYNC1  = 8'd0;
  localparam logic [7:0] OFS_SYNC2  = 8'd1;
  localparam logic [7:0] OFS_LEN    = 8'd2;
  localparam logic [7:0] OFS_SRC_HI = 8'd3;
  localparam logic [7:0] OFS_SRC_LO = 8'd4;
  localparam logic [7:0] OFS_TYPE   = 8'd5;
  localparam logic [7:0] OFS_STATE  = 8'd6;
  localparam logic [7:0] OFS_CMD    = 8'd7;
  localparam logic [7:0] OFS_ARG    = 8'd8;

  // Configuration register indexes
  localparam logic [1:0] CFG_SRC_HI    = 2'd0;
  localparam logic [1:0] CFG_SRC_LO    = 2'd1;
  localparam logic [1:0] CFG_MIN_BYTES = 2'd2;

  localparam logic [7:0] CFG_SRC_HI_RST    = 8'd0;
  localparam logic [7:0] CFG_SRC_LO_RST    = 8'd1;
  localparam logic [7:0] CFG_MIN_BYTES_RST = 8'd9;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_SYNC1 = 3'd2,
    ST_BAD_SYNC2 = 3'd3,
    ST_BAD_LEN   = 3'd4,
    ST_TRUNC     = 3'd5,
    ST_BAD_SRC   = 3'd6,
    ST_BAD_CRC   = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] src_hi;
    logic [7:0] src_lo;
    logic [7:0] min_bytes;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] ftype;
    logic [7:0] fstate;
    logic [7:0] cmd;
    logic [7:0] arg;
    logic [4:0] len;
  } result_t;

endpackage

[rtl/sfpc_crc_step.sv]
// One byte of CRC-16/MODBUS (reflected, poly 0xA001), unrolled over 8 bits.
module sfpc_crc_step (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ sfpc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

[rtl/sfpc_frame_tracker.sv]
// Per-packet state and the end-of-packet verdict.
module sfpc_frame_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  sfpc_pkg::cfg_t    cfg,
  output sfpc_pkg::result_t result
);

  logic [7:0]  cnt_r, cnt_nxt;
  logic        sync1_r, sync1_nxt;
  logic        sync2_r, sync2_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        src_r, src_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  state_r, state_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  arg_r, arg_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;

  logic [15:0] crc_step;
  logic        in_payload;
  logic        len_ok;
  logic [8:0]  pos_w;

  sfpc_crc_step u_crc (
    .crc_in  (crc_r),
    .data_in (data_byte),
    .crc_out (crc_step)
  );

  always_comb begin
    pos_w     = {1'b0, cnt_r};
    sync1_nxt = (cnt_r == sfpc_pkg::OFS_SYNC1) ? (data_byte == sfpc_pkg::SYNC_FIRST) : sync1_r;
    sync2_nxt = (cnt_r == sfpc_pkg::OFS_SYNC2) ? (data_byte == sfpc_pkg::SYNC_SECOND) : sync2_r;
    len_nxt   = (cnt_r == sfpc_pkg::OFS_LEN) ? data_byte : len_r;
    src_nxt   = src_r;
    if (cnt_r == sfpc_pkg::OFS_SRC_HI) begin
      src_nxt = (data_byte == cfg.src_hi);
    end else if (cnt_r == sfpc_pkg::OFS_SRC_LO) begin
      src_nxt = src_r && (data_byte == cfg.src_lo);
    end

    // Payload covers the length byte and the L bytes after it
    in_payload = (cnt_r >= sfpc_pkg::OFS_LEN) && ((cnt_r - sfpc_pkg::OFS_LEN) <= len_nxt);

    crc_nxt    = crc_r;
    type_nxt   = type_r;
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    arg_nxt    = arg_r;
    rx_crc_nxt = rx_crc_r;
    if (in_payload) begin
      crc_nxt = crc_step;
      if (cnt_r == sfpc_pkg::OFS_TYPE) begin
        type_nxt = data_byte;
      end else if (cnt_r == sfpc_pkg::OFS_STATE) begin
        state_nxt = data_byte;
      end else if (cnt_r == sfpc_pkg::OFS_CMD) begin
        cmd_nxt = data_byte;
      end else if (cnt_r == sfpc_pkg::OFS_ARG) begin
        arg_nxt = data_byte;
      end
    end else if ((cnt_r >= sfpc_pkg::OFS_LEN) && (pos_w == {1'b0, len_nxt} + 9'd3)) begin
      rx_crc_nxt = {data_byte, 8'h00};
    end else if ((cnt_r >= sfpc_pkg::OFS_LEN) && (pos_w == {1'b0, len_nxt} + 9'd4)) begin
      rx_crc_nxt = {rx_crc_r[15:8], data_byte};
    end

    // Saturate the byte count
    cnt_nxt = (cnt_r == sfpc_pkg::COUNT_MAX) ? cnt_r : cnt_r + 8'd1;

    len_ok = (len_nxt >= sfpc_pkg::LEN_MIN) && (len_nxt < sfpc_pkg::LENGTH_LIMIT);

    if (cnt_nxt < cfg.min_bytes) begin
      result.status = sfpc_pkg::ST_SHORT;
    end else if (!sync1_nxt) begin
      result.status = sfpc_pkg::ST_BAD_SYNC1;
    end else if (!sync2_nxt) begin
      result.status = sfpc_pkg::ST_BAD_SYNC2;
    end else if (!len_ok) begin
      result.status = sfpc_pkg::ST_BAD_LEN;
    end else if ({1'b0, cnt_nxt} < ({1'b0, len_nxt} + sfpc_pkg::HDR_AFTER_LEN)) begin
      result.status = sfpc_pkg::ST_TRUNC;
    end else if (!src_nxt) begin
      result.status = sfpc_pkg::ST_BAD_SRC;
    end else if (crc_nxt != rx_crc_nxt) begin
      result.status = sfpc_pkg::ST_BAD_CRC;
    end else begin
      result.status = sfpc_pkg::ST_OK;
    end

    if (result.status == sfpc_pkg::ST_OK) begin
      result.ftype  = type_nxt;
      result.fstate = state_nxt;
      result.cmd    = cmd_nxt;
      result.arg    = arg_nxt;
      result.len    = len_nxt[4:0];
    end else begin
      result.ftype  = 8'd0;
      result.fstate = 8'd0;
      result.cmd    = 8'd0;
      result.arg    = 8'd0;
      result.len    = 5'd0;
    end
  end

  // Drop all packet state on reset and after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && last_byte)) begin
      cnt_r    <= 8'd0;
      sync1_r  <= 1'b0;
      sync2_r  <= 1'b0;
      len_r    <= 8'd0;
      crc_r    <= sfpc_pkg::CRC_INIT;
      src_r    <= 1'b0;
      type_r   <= 8'd0;
      state_r  <= 8'd0;
      cmd_r    <= 8'd0;
      arg_r    <= 8'd0;
      rx_crc_r <= 16'd0;
    end else if (step_en) begin
      cnt_r    <= cnt_nxt;
      sync1_r  <= sync1_nxt;
      sync2_r  <= sync2_nxt;
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      src_r    <= src_nxt;
      type_r   <= type_nxt;
      state_r  <= state_nxt;
      cmd_r    <= cmd_nxt;
      arg_r    <= arg_nxt;
      rx_crc_r <= rx_crc_nxt;
    end
  end

endmodule

[rtl/sync_framed_packet_checker_crc16_unit.sv]
// Framed packet checker with on-the-fly CRC-16/MODBUS. Feed one received
// packet word per cycle on in_data_byte, with in_last_byte high on the final
// word. Each word lands in an input register and is checked from there by a
// single pass: the byte-wide CRC step, the header/source checks and the
// status priority chain. One result per packet is loaded into the out_
// register as the final word leaves the input register, which it does as
// soon as the result slot is free. Throughput is one word per cycle, set by
// the unrolled 8-bit CRC step; the only stall is a final word meeting a
// result that has not been taken. Fields of a failed packet read as zero.
// Configuration writes (source ID high/low, minimum packet size) take
// effect at once and belong only between packets.
`include "sync_framed_packet_checker_crc16_unit_defines.svh"

module sync_framed_packet_checker_crc16_unit (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  // Result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_frame_status,
  output logic [7:0] out_frame_type,
  output logic [7:0] out_frame_state,
  output logic [7:0] out_command_code,
  output logic [7:0] out_command_argument,
  output logic [4:0] out_payload_length,
  // Configuration port
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wr_data
);

  sfpc_pkg::cfg_t    cfg_r;
  sfpc_pkg::result_t res_w;
  sfpc_pkg::result_t out_res_r;

  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       out_valid_r;
  logic       out_free;
  logic       advance;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_hi    <= sfpc_pkg::CFG_SRC_HI_RST;
      cfg_r.src_lo    <= sfpc_pkg::CFG_SRC_LO_RST;
      cfg_r.min_bytes <= sfpc_pkg::CFG_MIN_BYTES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sfpc_pkg::CFG_SRC_HI:    cfg_r.src_hi    <= cfg_wr_data;
        sfpc_pkg::CFG_SRC_LO:    cfg_r.src_lo    <= cfg_wr_data;
        sfpc_pkg::CFG_MIN_BYTES: cfg_r.min_bytes <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // A final word needs a free result slot; other words always advance
  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  sfpc_frame_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .cfg       (cfg_r),
    .result    (res_w)
  );

  // Result register: load on a final word, hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_res_r <= res_w;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_frame_status     = out_res_r.status;
  assign out_frame_type       = out_res_r.ftype;
  assign out_frame_state      = out_res_r.fstate;
  assign out_command_code     = out_res_r.cmd;
  assign out_command_argument = out_res_r.arg;
  assign out_payload_length   = out_res_r.len;

  `SFPC_ASSERT_NEXT(a_last_gives_result, advance && s1_last_r, out_valid_r,
                    "final word did not produce a result")
  `SFPC_ASSERT_NOW(a_mid_word_no_stall, s1_valid_r && !s1_last_r, advance,
                   "non-final word stalled")
  `SFPC_ASSERT_NOW(a_ok_len_in_range,
                   out_valid_r && (out_res_r.status == sfpc_pkg::ST_OK),
                   out_res_r.len >= 5'd4,
                   "ok result with length below minimum")
  `SFPC_ASSERT_NOW(a_bad_fields_zero,
                   out_valid_r && (out_res_r.status != sfpc_pkg::ST_OK),
                   (out_res_r.ftype == 8'd0) && (out_res_r.len == 5'd0),
                   "failed packet carries nonzero fields")

endmodule

[test/sync_framed_packet_checker_crc16_unit_tb.sv]
`timescale 1ns / 1ps

module sync_framed_packet_checker_crc16_unit_tb;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_frame_status;
  logic [7:0] out_frame_type;
  logic [7:0] out_frame_state;
  logic [7:0] out_command_code;
  logic [7:0] out_command_argument;
  logic [4:0] out_payload_length;
  logic       cfg_wr_en;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wr_data;

  sync_framed_packet_checker_crc16_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_frame_status     (out_frame_status),
    .out_frame_type       (out_frame_type),
    .out_frame_state      (out_frame_state),
    .out_command_code     (out_command_code),
    .out_command_argument (out_command_argument),
    .out_payload_length   (out_payload_length),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wr_data          (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Register copies, kept in step with every write on the cfg_ port.
  logic [7:0] src_hi_reg;
  logic [7:0] src_lo_reg;
  logic [7:0] min_bytes_reg;

  // Per-packet tracking state of the checker, cleared after each final word.
  logic [7:0]  rx_count;
  bit          sync1_seen;
  bit          sync2_seen;
  logic [7:0]  len_byte;
  logic [15:0] crc_acc;
  bit          src_ok;
  logic [7:0]  cap_type;
  logic [7:0]  cap_state;
  logic [7:0]  cap_cmd;
  logic [7:0]  cap_arg;
  logic [15:0] crc_rx;

  sfpc_pkg::result_t frame_verdicts[$];   // verdicts owed by the block, oldest first
  logic [7:0] pkt_q[$];            // words of the packet being sent
  int         mismatches = 0;
  int         words_sent = 0;
  bit         no_gaps = 1'b0;      // both sides run back to back while set

  // One directed packet: an optional register setting to apply first, the
  // leading words, an optional CRC (with bits to flip), random trailing words
  // and, where the verdict is plain to see, the status typed in.
  typedef struct packed {
    bit                mset_cfg_unused_guard;
    logic [7:0]        src_hi;
    logic [7:0]        src_lo;
    logic [7:0]        min_bytes;
    logic [3:0]        nbytes;
    logic [0:11][7:0]  body;
    bit                add_crc;
    logic [15:0]       crc_flip;
    logic [1:0]        n_tail;
    bit                typed;
    sfpc_pkg::status_t typed_status;
  } dir_row_t;

  localparam int DIR_ROWS = 17;
  dir_row_t dir_tab [0:DIR_ROWS-1];

  initial begin
    dir_tab = '{
      // minimal good frame, all fields but the length zero
      '{1'b1, 8'h00, 8'h01, 8'd9, 4'd7, 96'h55_AA_04_00_01_00_00_00_00_00_00_00,
        1'b1, 16'h0000, 2'd0, 1'b0, sfpc_pkg::ST_OK},
      // command and argument inside the payload, all-ones data
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd9, 96'h55_AA_06_00_01_FF_FF_FF_FF_00_00_00,
        1'b1, 16'h0000, 2'd0, 1'b0, sfpc_pkg::ST_OK},
      // argument beyond the payload, trailing words after the CRC
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd8, 96'h55_AA_05_00_01_12_34_56_00_00_00_00,
        1'b1, 16'h0000, 2'd2, 1'b0, sfpc_pkg::ST_OK},
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd1, 96'h55_00_00_00_00_00_00_00_00_00_00_00,
        1'b0, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_SHORT},
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd7, 96'h00_AA_04_00_01_00_00_00_00_00_00_00,
        1'b1, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_BAD_SYNC1},
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd7, 96'h55_00_04_00_01_00_00_00_00_00_00_00,
        1'b1, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_BAD_SYNC2},
      // length just under the lower bound
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd9, 96'h55_AA_03_00_01_00_00_00_00_00_00_00,
        1'b0, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_BAD_LEN},
      // length at the limit
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd9, 96'h55_AA_1E_00_01_00_00_00_00_00_00_00,
        1'b0, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_BAD_LEN},
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd9, 96'h55_AA_06_00_01_00_00_00_00_00_00_00,
        1'b0, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_TRUNC},
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd7, 96'h55_AA_04_01_01_00_00_00_00_00_00_00,
        1'b1, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_BAD_SRC},
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd7, 96'h55_AA_04_00_01_00_00_00_00_00_00_00,
        1'b1, 16'h0001, 2'd0, 1'b1, sfpc_pkg::ST_BAD_CRC},
      // no minimum size: packets that end inside the header
      '{1'b1, 8'hFF, 8'hFF, 8'd0, 4'd1, 96'h00_00_00_00_00_00_00_00_00_00_00_00,
        1'b0, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_BAD_SYNC1},
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd1, 96'h55_00_00_00_00_00_00_00_00_00_00_00,
        1'b0, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_BAD_SYNC2},
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd2, 96'h55_AA_00_00_00_00_00_00_00_00_00_00,
        1'b0, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_BAD_LEN},
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd3, 96'h55_AA_04_00_00_00_00_00_00_00_00_00,
        1'b0, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_TRUNC},
      '{1'b0, 8'h00, 8'h00, 8'd0, 4'd7, 96'h55_AA_04_FF_FF_80_7F_00_00_00_00_00,
        1'b1, 16'h0000, 2'd0, 1'b0, sfpc_pkg::ST_OK},
      // largest minimum size
      '{1'b1, 8'hFF, 8'hFF, 8'hFF, 4'd7, 96'h55_AA_04_FF_FF_01_02_00_00_00_00_00,
        1'b1, 16'h0000, 2'd0, 1'b1, sfpc_pkg::ST_SHORT}
    };
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ sfpc_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_tracking();
    rx_count   = '0;
    sync1_seen = 1'b0;
    sync2_seen = 1'b0;
    len_byte   = '0;
    crc_acc    = sfpc_pkg::CRC_INIT;
    src_ok     = 1'b0;
    cap_type   = '0;
    cap_state  = '0;
    cap_cmd    = '0;
    cap_arg    = '0;
    crc_rx     = '0;
  endfunction

  // Advance the tracking state by one accepted word; on the final word,
  // return 1 with the verdict the block owes and start a fresh packet.
  function automatic bit frame_check_byte(input logic [7:0] b, input logic last,
                                          output sfpc_pkg::result_t verdict);
    int  p;
    int  l;
    int  total;
    bit  len_good;
    p = rx_count;
    if (p == sfpc_pkg::OFS_SYNC1) begin
      sync1_seen = (b == sfpc_pkg::SYNC_FIRST);
    end else if (p == sfpc_pkg::OFS_SYNC2) begin
      sync2_seen = (b == sfpc_pkg::SYNC_SECOND);
    end else if (p == sfpc_pkg::OFS_LEN) begin
      len_byte = b;
    end else if (p == sfpc_pkg::OFS_SRC_HI) begin
      src_ok = (b == src_hi_reg);
    end else if (p == sfpc_pkg::OFS_SRC_LO) begin
      src_ok = src_ok && (b == src_lo_reg);
    end
    l = len_byte;
    // Length word and payload feed the CRC; the two words after it carry it.
    if (p >= 2 && p - 2 <= l) begin
      crc_acc = crc16_step(crc_acc, b);
      if (p == sfpc_pkg::OFS_TYPE) cap_type = b;
      else if (p == sfpc_pkg::OFS_STATE) cap_state = b;
      else if (p == sfpc_pkg::OFS_CMD) cap_cmd = b;
      else if (p == sfpc_pkg::OFS_ARG) cap_arg = b;
    end else if (p >= 2 && p == l + 3) begin
      crc_rx = {b, 8'h00};
    end else if (p >= 2 && p == l + 4) begin
      crc_rx = {crc_rx[15:8], b};
    end
    if (rx_count != sfpc_pkg::COUNT_MAX) rx_count = rx_count + 8'd1;
    verdict = '0;
    if (!last) return 1'b0;
    total    = rx_count;
    len_good = (len_byte >= sfpc_pkg::LEN_MIN) && (len_byte < sfpc_pkg::LENGTH_LIMIT);
    if (total < min_bytes_reg)                    verdict.status = sfpc_pkg::ST_SHORT;
    else if (!sync1_seen)                         verdict.status = sfpc_pkg::ST_BAD_SYNC1;
    else if (!sync2_seen)                         verdict.status = sfpc_pkg::ST_BAD_SYNC2;
    else if (!len_good)                           verdict.status = sfpc_pkg::ST_BAD_LEN;
    else if (total < l + sfpc_pkg::HDR_AFTER_LEN) verdict.status = sfpc_pkg::ST_TRUNC;
    else if (!src_ok)                             verdict.status = sfpc_pkg::ST_BAD_SRC;
    else if (crc_acc != crc_rx)                   verdict.status = sfpc_pkg::ST_BAD_CRC;
    else begin
      verdict.status = sfpc_pkg::ST_OK;
      verdict.ftype  = cap_type;
      verdict.fstate = cap_state;
      verdict.cmd    = cap_cmd;
      verdict.arg    = cap_arg;
      verdict.len    = len_byte[4:0];
    end
    clear_tracking();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    return no_gaps ? 0 : $urandom_range(0, 12);
  endfunction

  // Fill pkt_q with a framed packet of payload length plen.
  task automatic build_frame(input int plen, input bit good_src, input bit good_crc,
                             input int n_tail);
    logic [15:0] crc;
    pkt_q.delete();
    pkt_q.push_back(sfpc_pkg::SYNC_FIRST);
    pkt_q.push_back(sfpc_pkg::SYNC_SECOND);
    pkt_q.push_back(8'(plen));
    pkt_q.push_back(good_src ? src_hi_reg : 8'($urandom_range(0, 255)));
    pkt_q.push_back(good_src ? src_lo_reg : 8'($urandom_range(0, 255)));
    for (int i = 2; i < plen; i++) pkt_q.push_back(8'($urandom_range(0, 255)));
    crc = sfpc_pkg::CRC_INIT;
    for (int i = 2; i < pkt_q.size(); i++) crc = crc16_step(crc, pkt_q[i]);
    if (!good_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    pkt_q.push_back(crc[15:8]);
    pkt_q.push_back(crc[7:0]);
    for (int i = 0; i < n_tail; i++) pkt_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Send pkt_q word by word; the final word carries the last mark. A typed
  // status replaces the tracked verdict with that status and zero fields.
  task automatic send_packet(input bit typed, input sfpc_pkg::status_t typed_status);
    int                gap;
    bit                got;
    sfpc_pkg::result_t verdict;
    for (int i = 0; i < pkt_q.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_data_byte <= pkt_q[i];
      in_last_byte <= (i == pkt_q.size() - 1);
      do @(posedge clk); while (!in_ready);
      words_sent++;
      got = frame_check_byte(pkt_q[i], i == pkt_q.size() - 1, verdict);
      if (got) begin
        if (typed) begin
          verdict        = '0;
          verdict.status = typed_status;
        end
        frame_verdicts.push_back(verdict);
      end
    end
  endtask

  // Drop valid and let every owed verdict drain before touching registers.
  task automatic go_idle();
    in_valid <= 1'b0;
    while (frame_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on back-to-back edges; hold the enable high.
  task automatic apply_cfg(input logic [7:0] hi, input logic [7:0] lo, input logic [7:0] mn);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= sfpc_pkg::CFG_SRC_HI;
    cfg_wr_data <= hi;
    @(posedge clk);
    cfg_index   <= sfpc_pkg::CFG_SRC_LO;
    cfg_wr_data <= lo;
    @(posedge clk);
    cfg_index   <= sfpc_pkg::CFG_MIN_BYTES;
    cfg_wr_data <= mn;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    src_hi_reg    = hi;
    src_lo_reg    = lo;
    min_bytes_reg = mn;
  endtask

  function automatic void match_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver: draw a stall before each verdict, then hold ready until taken.
  initial begin
    int                gap;
    sfpc_pkg::result_t want;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (frame_verdicts.size() == 0) begin
        $error("frame verdict with none owed: status %0d", out_frame_status);
        mismatches++;
      end else begin
        want = frame_verdicts.pop_front();
        match_field("frame_status", want.status, out_frame_status);
        match_field("frame_type", want.ftype, out_frame_type);
        match_field("frame_state", want.fstate, out_frame_state);
        match_field("command_code", want.cmd, out_command_code);
        match_field("command_argument", want.arg, out_command_argument);
        match_field("payload_length", want.len, out_payload_length);
      end
    end
  end

  // Stimulus: reset, directed table, then random packets in config phases.
  initial begin
    int         rand_start;
    int         pkt_idx;
    int         k;
    int         plen;
    int         cut;
    int         n;
    int         r;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] mn;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= sfpc_pkg::CFG_SRC_HI;
    cfg_wr_data  <= 8'h00;
    src_hi_reg    = sfpc_pkg::CFG_SRC_HI_RST;
    src_lo_reg    = sfpc_pkg::CFG_SRC_LO_RST;
    min_bytes_reg = sfpc_pkg::CFG_MIN_BYTES_RST;
    clear_tracking();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table.
    for (int row = 0; row < DIR_ROWS; row++) begin
      if (dir_tab[row].mset_cfg_unused_guard) begin
        go_idle();
        apply_cfg(dir_tab[row].src_hi, dir_tab[row].src_lo, dir_tab[row].min_bytes);
      end
      pkt_q.delete();
      for (int i = 0; i < dir_tab[row].nbytes; i++) pkt_q.push_back(dir_tab[row].body[i]);
      if (dir_tab[row].add_crc) begin
        logic [15:0] crc;
        crc = sfpc_pkg::CRC_INIT;
        for (int i = 2; i < pkt_q.size(); i++) crc = crc16_step(crc, pkt_q[i]);
        crc = crc ^ dir_tab[row].crc_flip;
        pkt_q.push_back(crc[15:8]);
        pkt_q.push_back(crc[7:0]);
      end
      for (int i = 0; i < dir_tab[row].n_tail; i++) pkt_q.push_back(8'($urandom_range(0, 255)));
      no_gaps = ($urandom_range(0, 3) == 0);
      send_packet(dir_tab[row].typed, dir_tab[row].typed_status);
    end

    // Random part: mostly well-formed frames, the rest broken or noise.
    rand_start = words_sent;
    pkt_idx    = 0;
    while (words_sent - rand_start < 1350) begin
      if (pkt_idx % 20 == 0) begin
        r  = $urandom_range(0, 3);
        hi = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        r  = $urandom_range(0, 3);
        lo = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        r  = $urandom_range(0, 9);
        mn = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF :
             (r <= 4) ? 8'd9 : 8'($urandom_range(1, 14));
        go_idle();
        apply_cfg(hi, lo, mn);
      end
      plen = ($urandom_range(0, 4) != 0) ? $urandom_range(4, 10) : $urandom_range(4, 29);
      if (pkt_idx == 15) begin
        // Good frame with a long tail: drive the word count into saturation.
        build_frame(4, 1'b1, 1'b1, 262);
      end else if (pkt_idx == 60) begin
        // Oversize length word followed by enough noise to saturate the count.
        pkt_q.delete();
        pkt_q.push_back(sfpc_pkg::SYNC_FIRST);
        pkt_q.push_back(sfpc_pkg::SYNC_SECOND);
        pkt_q.push_back(8'hFF);
        for (int i = 0; i < 277; i++) pkt_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        k = $urandom_range(0, 99);
        if (k < 70) begin
          build_frame(plen, $urandom_range(0, 6) != 0, $urandom_range(0, 9) != 0,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
        end else if (k < 80) begin
          // Truncate a good frame at a random point.
          build_frame(plen, 1'b1, 1'b1, 0);
          cut = $urandom_range(1, pkt_q.size() - 1);
          while (pkt_q.size() > cut) pkt_q.delete(pkt_q.size() - 1);
        end else if (k < 90) begin
          // Overwrite one header word.
          build_frame(plen, 1'b1, 1'b1, 0);
          pkt_q[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
        end else begin
          pkt_q.delete();
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) pkt_q.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1) == 1) begin
            pkt_q[0] = sfpc_pkg::SYNC_FIRST;
            if (n > 1) pkt_q[1] = sfpc_pkg::SYNC_SECOND;
          end
        end
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      send_packet(1'b0, sfpc_pkg::ST_OK);
      pkt_idx++;
    end

    // Drain, then give the block time to show any stray verdict.
    in_valid <= 1'b0;
    while (frame_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/sfpc_pkg.sv
rtl/sfpc_crc_step.sv
rtl/sfpc_frame_tracker.sv
rtl/sync_framed_packet_checker_crc16_unit.sv
test/sync_framed_packet_checker_crc16_unit_tb.sv
